// ----- rtl/b64enc_pkg.sv -----
// b64enc_pkg: shared types, constants and the alphabet lookup of the base64 encoder
// no dependencies; used by every module under rtl
`default_nettype none

package b64enc_pkg;

	localparam logic [6:0] PAD_CHAR = 7'd61;   // '='

	// one 3-byte group as handed from the front to the back
	typedef struct packed {
		logic [23:0] word;       // first byte in the top bits, missing bytes zero
		logic [1:0]  nbytes;     // real bytes in the group, 1 to 3
		logic        is_final;   // group closed by the message's final byte
	} group_t;

	// standard alphabet: A-Z, a-z, 0-9, '+', '/'
	function automatic logic [6:0] b64_char(input logic [5:0] idx);
		logic [6:0] ch;
		if (idx < 6'd26) begin
			ch = 7'd65 + {1'b0, idx};
		end else if (idx < 6'd52) begin
			ch = 7'd97 + {1'b0, idx - 6'd26};
		end else if (idx < 6'd62) begin
			ch = 7'd48 + {1'b0, idx - 6'd52};
		end else if (idx == 6'd62) begin
			ch = 7'd43;
		end else begin
			ch = 7'd47;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/b64enc_front.sv -----
// b64enc_front: accepts bytes and collects them into 3-byte groups
// depends on b64enc_pkg (group_t)
`default_nettype none

module b64enc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         data_byte,
	input  wire logic               final_byte,
	output logic                    push,
	output b64enc_pkg::group_t      push_group,
	input  wire logic               push_ready
);

	logic [1:0] fill_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic [1:0] held;
	logic       closes;
	logic       accept;

	// fill count three cannot occur; it reads as an empty group
	assign held     = (fill_q == 2'd3) ? 2'd0 : fill_q;
	assign closes   = final_byte || (held == 2'd2);
	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign push     = accept && closes;

	always_comb begin
		push_group.is_final = final_byte;
		case (held)
			2'd2: begin
				push_group.word   = {first_q, second_q, data_byte};
				push_group.nbytes = 2'd3;
			end
			2'd1: begin
				push_group.word   = {first_q, data_byte, 8'd0};
				push_group.nbytes = 2'd2;
			end
			default: begin
				push_group.word   = {data_byte, 16'd0};
				push_group.nbytes = 2'd1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= 2'd0;
		end else if (accept) begin
			fill_q <= closes ? 2'd0 : held + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !closes && held == 2'd0) begin
			first_q <= data_byte;
		end
		if (accept && !closes && held == 2'd1) begin
			second_q <= data_byte;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) fill_q != 2'd3)
		else $error("front fill count reached three");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !closes) |=> (fill_q != 2'd0))
		else $error("held byte lost from open group");

endmodule

`default_nettype wire

// ----- rtl/b64enc_queue.sv -----
// b64enc_queue: short group queue between the front and the back
// depends on b64enc_pkg (group_t)
`default_nettype none

module b64enc_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire b64enc_pkg::group_t push_group,
	output logic                    push_ready,
	input  wire logic               pop,
	output b64enc_pkg::group_t      pop_group,
	output logic                    pop_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	b64enc_pkg::group_t slots_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_group  = slots_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_group;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> push_ready)
		else $error("push into full group queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> pop_valid)
		else $error("pop from empty group queue");

endmodule

`default_nettype wire

// ----- rtl/b64enc_back.sv -----
// b64enc_back: turns queued groups into four characters, one per cycle while the output is not stalled
// depends on b64enc_pkg (group_t, b64_char, PAD_CHAR)
`default_nettype none

module b64enc_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire b64enc_pkg::group_t pop_group,
	input  wire logic               pop_valid,
	output logic                    pop,
	output logic [6:0]              char_code,
	output logic                    last_char,
	output logic                    out_valid,
	input  wire logic               out_ready
);

	b64enc_pkg::group_t grp_q;
	logic               busy_q;
	logic [1:0]         k_q;
	logic [6:0]         char_q;
	logic               last_q;
	logic               valid_q;
	logic               slot_free;
	logic               advance;
	logic [5:0]         idx;
	logic [6:0]         next_char;

	assign slot_free = !valid_q || out_ready;
	assign advance   = busy_q && slot_free;
	assign pop       = pop_valid && (!busy_q || (advance && k_q == 2'd3));

	always_comb begin
		case (k_q)
			2'd0:    idx = grp_q.word[23:18];
			2'd1:    idx = grp_q.word[17:12];
			2'd2:    idx = grp_q.word[11:6];
			default: idx = grp_q.word[5:0];
		endcase
		next_char = (k_q > grp_q.nbytes) ? b64enc_pkg::PAD_CHAR : b64enc_pkg::b64_char(idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			k_q     <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				k_q    <= 2'd0;
			end else if (advance) begin
				busy_q <= (k_q != 2'd3);
				k_q    <= k_q + 2'd1;
			end
			if (advance) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			grp_q <= pop_group;
		end
		if (advance) begin
			char_q <= next_char;
			last_q <= grp_q.is_final && (k_q == 2'd3);
		end
	end

	assign char_code = char_q;
	assign last_char = last_q;
	assign out_valid = valid_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		(!busy_q) |-> (k_q == 2'd0))
		else $error("character index left nonzero when idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && k_q == 2'd0) |=> (char_q != b64enc_pkg::PAD_CHAR))
		else $error("pad emitted as first character of a group");

endmodule

`default_nettype wire

// ----- rtl/base64_encoder.sv -----
// base64_encoder: top level of the streaming base64 encoder
// depends on b64enc_pkg, b64enc_front, b64enc_queue, b64enc_back
`default_nettype none

// Streaming base64 encoder, standard alphabet with '=' padding. Raw bytes come
// in one per request on data_byte, with final_byte high on the last byte of a
// message. Every third byte, or the final byte, closes a group of up to three
// bytes; the group turns into four ASCII characters on char_code, one per
// request, and last_char marks the fourth character of the group that the
// final byte closed. A one-byte tail gives two '=' pads, a two-byte tail one.
// Bytes that only fill a group give no output. The output side sends one
// character per cycle while out_ready is high, so the character serializer in
// the back end sets the rate of a steady stream. A group queue of QUEUE_DEPTH
// entries sits between the byte collector and the serializer, and a character
// register sits on the output, so input keeps flowing while output is stalled
// until the queue fills.
module base64_encoder #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       final_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [6:0]      char_code,
	output logic            last_char
);

	// front to queue
	logic               push;
	logic               push_ready;
	b64enc_pkg::group_t push_group;

	// queue to back
	logic               pop;
	logic               pop_valid;
	b64enc_pkg::group_t pop_group;

	// byte collector: closes a group on the third or final byte
	b64enc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.push       (push),
		.push_group (push_group),
		.push_ready (push_ready)
	);

	// decouples the collector from the serializer
	b64enc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_group  (pop_group),
		.pop_valid  (pop_valid)
	);

	// serializer: four characters per group, pads for missing bytes
	b64enc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_group (pop_group),
		.pop_valid (pop_valid),
		.pop       (pop),
		.char_code (char_code),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

endmodule

`default_nettype wire
